### hdl/assert_macros.svh
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define PFT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define PFT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Checks what a reset cycle leaves behind; active through reset.
`define PFT_ASSERT_AFTER_RESET(lbl, clk, rst, cons, msg) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

### hdl/pft_pkg.sv
package pft_pkg;

   // Field widths of the item payloads.
   localparam int POS_W  = 32;
   localparam int HEAD_W = 24;
   localparam int VEC_W  = POS_W + 1;
   localparam int HS_W   = HEAD_W + 1;

   // Sine table magnitude width; signed sine and cosine are one bit wider.
   localparam int SINE_W = 15;

   localparam int TABLE_ENTRIES_DEFAULT = 1024;

   // Stages of the sine and cosine lookup pipeline.
   localparam int TRIG_STAGES = 7;

   // Angle constants in hundredths of a degree.
   localparam int CDEG_TURN    = 36000;
   localparam int CDEG_QUARTER = 9000;

   // Q30 constants for building the table.
   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam longint unsigned ONE_Q30 = 64'd1073741824;

   // Operation codes of the func field.
   typedef enum logic [1:0] {
      FUNC_POSE_TO_ABS = 2'd0,
      FUNC_POSE_TO_REL = 2'd1,
      FUNC_VEC_FWD     = 2'd2,
      FUNC_VEC_INV     = 2'd3
   } func_type;

   // Payload carried alongside the trig pipeline.
   typedef struct packed {
      func_type                  func;
      logic signed [POS_W-1:0]   base_x;
      logic signed [POS_W-1:0]   base_y;
      logic signed [VEC_W-1:0]   vec_x;
      logic signed [VEC_W-1:0]   vec_y;
      logic signed [HS_W-1:0]    heading;
   } pft_payload_type;

   // Sine of a Q30 angle by a Taylor series to the fifteenth power,
   // scaled to Q1.15, rounded and clamped. Used only at elaboration.
   function automatic logic [SINE_W-1:0] sine_series(input longint unsigned x);
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned e;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - term;
      e = (sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (e > 64'd32767) begin
         e = 64'd32767;
      end
      return e[SINE_W-1:0];
   endfunction

endpackage

### hdl/pft_channel_if.sv
// Input channel: one transform request per item.
interface pft_req_if;
   import pft_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                func;
   logic signed [POS_W-1:0]   base_x;
   logic signed [POS_W-1:0]   base_y;
   logic signed [HEAD_W-1:0]  base_heading;
   logic signed [POS_W-1:0]   in_x;
   logic signed [POS_W-1:0]   in_y;
   logic signed [HEAD_W-1:0]  in_heading;

   modport source (
      output valid, func, base_x, base_y, base_heading, in_x, in_y, in_heading,
      input  ready
   );

   modport sink (
      input  valid, func, base_x, base_y, base_heading, in_x, in_y, in_heading,
      output ready
   );
endinterface

// Result channel: one transformed pose or vector per item.
interface pft_rsp_if;
   import pft_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [POS_W-1:0]   out_x;
   logic signed [POS_W-1:0]   out_y;
   logic signed [HEAD_W-1:0]  out_heading;
   logic                      saturated;

   modport source (
      output valid, out_x, out_y, out_heading, saturated,
      input  ready
   );

   modport sink (
      input  valid, out_x, out_y, out_heading, saturated,
      output ready
   );
endinterface

### hdl/pft_sincos.sv
module pft_sincos #(
   parameter int TABLE_ENTRIES = pft_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                                 clock,
   input  logic [pft_pkg::TRIG_STAGES-1:0]      stage_en,
   input  logic signed [pft_pkg::HEAD_W-1:0]    heading,
   output logic signed [pft_pkg::SINE_W:0]      sin_q15,
   output logic signed [pft_pkg::SINE_W:0]      cos_q15
);
   import pft_pkg::*;

   // Heading offset that makes every heading positive, a whole number of turns.
   localparam int U_W         = HEAD_W + 1;
   localparam int HEAD_OFFSET = CDEG_TURN * ((2 ** (HEAD_W - 1)) / CDEG_TURN + 1);
   localparam int MOD_SHIFT   = U_W + 16;
   localparam longint unsigned MOD_RECIP =
      ((64'd1 << MOD_SHIFT) + CDEG_TURN - 1) / CDEG_TURN;
   localparam int MOD_RECIP_W = $clog2(MOD_RECIP + 1);
   localparam int TURN_W      = $clog2((2 ** U_W) / CDEG_TURN + 1);
   localparam int R_W         = $clog2(CDEG_TURN);
   localparam int M_W         = $clog2(CDEG_QUARTER);

   // Index scaling: idx = (m * (entries - 1) + quarter / 2) / quarter.
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam longint unsigned P_MAX =
      64'(CDEG_QUARTER - 1) * 64'(TABLE_ENTRIES - 1) + 64'(CDEG_QUARTER / 2);
   localparam int P_W       = $clog2(P_MAX + 1);
   localparam int IDX_SHIFT = P_W + 14;
   localparam longint unsigned IDX_RECIP =
      ((64'd1 << IDX_SHIFT) + CDEG_QUARTER - 1) / CDEG_QUARTER;
   localparam int IDX_RECIP_W = $clog2(IDX_RECIP + 1);

   // Quarter-wave sine table, fixed at elaboration.
   logic [SINE_W-1:0] sine_rom [TABLE_ENTRIES];

   for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_rom
      localparam longint unsigned ANGLE_Q30 =
         64'(gi) * PI_Q30 / (64'd2 * 64'(TABLE_ENTRIES - 1));
      assign sine_rom[gi] = sine_series(ANGLE_Q30);
   end

   logic [U_W-1:0]                 u_in;
   logic [U_W+MOD_RECIP_W-1:0]     turn_prod;
   logic [U_W-1:0]                 u1_ff;
   logic [TURN_W-1:0]              turns1_ff;
   logic [R_W-1:0]                 r_in;
   logic [R_W-1:0]                 r2_ff;
   logic [1:0]                     quad_in;
   logic [M_W-1:0]                 m_in;
   logic [1:0]                     quad3_ff;
   logic [M_W-1:0]                 m3_ff;
   logic [P_W-1:0]                 p_in;
   logic [1:0]                     quad4_ff;
   logic [P_W-1:0]                 p4_ff;
   logic [P_W+IDX_RECIP_W-1:0]     idx_prod;
   logic [1:0]                     quad5_ff;
   logic [IDX_W-1:0]               idx5_ff;
   logic [IDX_W-1:0]               sin_addr;
   logic [IDX_W-1:0]               cos_addr;
   logic [SINE_W-1:0]              sin_rom6_ff;
   logic [SINE_W-1:0]              cos_rom6_ff;
   logic                           sin_neg6_ff;
   logic                           cos_neg6_ff;
   logic signed [SINE_W:0]         sin_mag;
   logic signed [SINE_W:0]         cos_mag;
   logic signed [SINE_W:0]         sin_ff;
   logic signed [SINE_W:0]         cos_ff;

   // Stage 1: shift the heading positive and estimate the whole turns in it.
   assign u_in      = U_W'(heading) + U_W'(HEAD_OFFSET);
   assign turn_prod = (U_W + MOD_RECIP_W)'(u_in) * (U_W + MOD_RECIP_W)'(MOD_RECIP);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         u1_ff     <= u_in;
         turns1_ff <= TURN_W'(turn_prod >> MOD_SHIFT);
      end
   end

   // Stage 2: the remainder is the heading reduced to one turn.
   assign r_in = R_W'(u1_ff - U_W'(turns1_ff * U_W'(CDEG_TURN)));

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         r2_ff <= r_in;
      end
   end

   // Stage 3: split the angle into a quadrant and an offset within it.
   always_comb begin
      if (r2_ff >= R_W'(3 * CDEG_QUARTER)) begin
         quad_in = 2'd3;
         m_in    = M_W'(r2_ff - R_W'(3 * CDEG_QUARTER));
      end else if (r2_ff >= R_W'(2 * CDEG_QUARTER)) begin
         quad_in = 2'd2;
         m_in    = M_W'(r2_ff - R_W'(2 * CDEG_QUARTER));
      end else if (r2_ff >= R_W'(CDEG_QUARTER)) begin
         quad_in = 2'd1;
         m_in    = M_W'(r2_ff - R_W'(CDEG_QUARTER));
      end else begin
         quad_in = 2'd0;
         m_in    = M_W'(r2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         quad3_ff <= quad_in;
         m3_ff    <= m_in;
      end
   end

   // Stage 4: scale the offset to table steps, with half a step for rounding.
   assign p_in = P_W'(m3_ff) * P_W'(TABLE_ENTRIES - 1) + P_W'(CDEG_QUARTER / 2);

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         quad4_ff <= quad3_ff;
         p4_ff    <= p_in;
      end
   end

   // Stage 5: divide by a quarter turn through a rounded-up reciprocal that gives the exact quotient.
   assign idx_prod = (P_W + IDX_RECIP_W)'(p4_ff) * (P_W + IDX_RECIP_W)'(IDX_RECIP);

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         quad5_ff <= quad4_ff;
         idx5_ff  <= IDX_W'(idx_prod >> IDX_SHIFT);
      end
   end

   // Stage 6: table reads. The cosine sits one quadrant ahead of the sine
   // with the same offset, so it reads the mirror of the sine's table address.
   always_comb begin
      if (quad5_ff[0]) begin
         sin_addr = IDX_W'(TABLE_ENTRIES - 1) - idx5_ff;
         cos_addr = idx5_ff;
      end else begin
         sin_addr = idx5_ff;
         cos_addr = IDX_W'(TABLE_ENTRIES - 1) - idx5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         sin_rom6_ff <= sine_rom[sin_addr];
         cos_rom6_ff <= sine_rom[cos_addr];
         sin_neg6_ff <= quad5_ff[1];
         cos_neg6_ff <= quad5_ff[1] ^ quad5_ff[0];
      end
   end

   // Stage 7: apply the quadrant sign.
   assign sin_mag = $signed({1'b0, sin_rom6_ff});
   assign cos_mag = $signed({1'b0, cos_rom6_ff});

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         sin_ff <= sin_neg6_ff ? -sin_mag : sin_mag;
         cos_ff <= cos_neg6_ff ? -cos_mag : cos_mag;
      end
   end

   assign sin_q15 = sin_ff;
   assign cos_q15 = cos_ff;

endmodule

### hdl/planar_pose_frame_transform.sv
// Throughput: one item per cycle; each stage holds its item while the next
// stage is full, so the pipeline fills up under a stalled output.
// Seven of the stages are the sine and cosine lookup from the base heading.
// Reset (synchronous, active high) clears only the stage valid bits; the
// sine table is a constant and needs no start-up pass.
module planar_pose_frame_transform #(
   parameter int TABLE_ENTRIES = pft_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   pft_req_if.sink     req_port,
   pft_rsp_if.source   rsp_port
);
   import pft_pkg::*;

   localparam int NUM_STAGES = TRIG_STAGES + 3;
   localparam int PROD_W     = SINE_W + 1 + VEC_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int RND_W      = SUM_W - 15;
   localparam int OX_W       = RND_W + 1;
   localparam int ROUND_BIAS = 1 << 14;

   logic [NUM_STAGES-1:0]     valid_ff;
   logic [NUM_STAGES-1:0]     valid_in;
   logic [NUM_STAGES-1:0]     stage_en;

   func_type                  func_in;
   pft_payload_type           pay_in;
   pft_payload_type           pay_ff [NUM_STAGES-1];

   logic signed [SINE_W:0]    sin_q15;
   logic signed [SINE_W:0]    cos_q15;

   logic signed [PROD_W-1:0]  prod_ca_ff;
   logic signed [PROD_W-1:0]  prod_sb_ff;
   logic signed [PROD_W-1:0]  prod_sa_ff;
   logic signed [PROD_W-1:0]  prod_cb_ff;

   logic signed [SUM_W-1:0]   sum_x;
   logic signed [SUM_W-1:0]   sum_y;
   logic signed [SUM_W-1:0]   bias_x;
   logic signed [SUM_W-1:0]   bias_y;
   logic signed [RND_W-1:0]   rnd_x_ff;
   logic signed [RND_W-1:0]   rnd_y_ff;

   logic signed [OX_W-1:0]    base_x_add;
   logic signed [OX_W-1:0]    base_y_add;
   logic signed [OX_W-1:0]    ox_wide;
   logic signed [OX_W-1:0]    oy_wide;
   logic [OX_W-POS_W:0]       ox_top;
   logic [OX_W-POS_W:0]       oy_top;
   logic [1:0]                oh_top;
   logic                      ox_fit;
   logic                      oy_fit;
   logic                      oh_fit;

   logic signed [POS_W-1:0]   out_x_in;
   logic signed [POS_W-1:0]   out_y_in;
   logic signed [HEAD_W-1:0]  out_heading_in;
   logic                      saturated_in;
   logic signed [POS_W-1:0]   out_x_ff;
   logic signed [POS_W-1:0]   out_y_ff;
   logic signed [HEAD_W-1:0]  out_heading_ff;
   logic                      saturated_ff;

   // A stage may load when it is empty or when the stage after it loads.
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_port.ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   always_comb begin
      valid_in[0] = stage_en[0] ? req_port.valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = stage_en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_port.ready = stage_en[0];

   // Stage 1: offsets and heading sum or difference, chosen by operation.
   assign func_in = func_type'(req_port.func);

   always_comb begin
      pay_in.func   = func_in;
      pay_in.base_x = req_port.base_x;
      pay_in.base_y = req_port.base_y;
      unique case (func_in) inside
         FUNC_POSE_TO_ABS: begin
            pay_in.vec_x   = VEC_W'(req_port.in_x);
            pay_in.vec_y   = VEC_W'(req_port.in_y);
            pay_in.heading = HS_W'(req_port.in_heading) + HS_W'(req_port.base_heading);
         end
         FUNC_POSE_TO_REL: begin
            pay_in.vec_x   = VEC_W'(req_port.in_x) - VEC_W'(req_port.base_x);
            pay_in.vec_y   = VEC_W'(req_port.in_y) - VEC_W'(req_port.base_y);
            pay_in.heading = HS_W'(req_port.in_heading) - HS_W'(req_port.base_heading);
         end
         FUNC_VEC_FWD, FUNC_VEC_INV: begin
            pay_in.vec_x   = VEC_W'(req_port.in_x);
            pay_in.vec_y   = VEC_W'(req_port.in_y);
            pay_in.heading = HS_W'(req_port.in_heading);
         end
         default: begin
            pay_in.vec_x   = VEC_W'(req_port.in_x);
            pay_in.vec_y   = VEC_W'(req_port.in_y);
            pay_in.heading = HS_W'(req_port.in_heading);
         end
      endcase
   end

   // The payload travels beside the trig pipeline and the arithmetic stages.
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pay_ff[0] <= pay_in;
      end
      for (int i = 1; i < NUM_STAGES - 1; i++) begin
         if (stage_en[i]) begin
            pay_ff[i] <= pay_ff[i-1];
         end
      end
   end

   pft_sincos #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_sincos (
      .clock    (clock),
      .stage_en (stage_en[TRIG_STAGES-1:0]),
      .heading  (req_port.base_heading),
      .sin_q15  (sin_q15),
      .cos_q15  (cos_q15)
   );

   // Stage 8: the four rotation products.
   always_ff @(posedge clock) begin
      if (stage_en[TRIG_STAGES]) begin
         prod_ca_ff <= PROD_W'(cos_q15) * PROD_W'(pay_ff[TRIG_STAGES-1].vec_x);
         prod_sb_ff <= PROD_W'(sin_q15) * PROD_W'(pay_ff[TRIG_STAGES-1].vec_y);
         prod_sa_ff <= PROD_W'(sin_q15) * PROD_W'(pay_ff[TRIG_STAGES-1].vec_x);
         prod_cb_ff <= PROD_W'(cos_q15) * PROD_W'(pay_ff[TRIG_STAGES-1].vec_y);
      end
   end

   // Stage 9: combine the products by direction and round to nearest.
   always_comb begin
      case (pay_ff[TRIG_STAGES].func) inside
         FUNC_POSE_TO_ABS, FUNC_VEC_FWD: begin
            sum_x = SUM_W'(prod_ca_ff) - SUM_W'(prod_sb_ff);
            sum_y = SUM_W'(prod_sa_ff) + SUM_W'(prod_cb_ff);
         end
         default: begin
            sum_x = SUM_W'(prod_ca_ff) + SUM_W'(prod_sb_ff);
            sum_y = SUM_W'(prod_cb_ff) - SUM_W'(prod_sa_ff);
         end
      endcase
      bias_x = sum_x + SUM_W'(ROUND_BIAS);
      bias_y = sum_y + SUM_W'(ROUND_BIAS);
   end

   always_ff @(posedge clock) begin
      if (stage_en[TRIG_STAGES+1]) begin
         rnd_x_ff <= RND_W'(bias_x >>> 15);
         rnd_y_ff <= RND_W'(bias_y >>> 15);
      end
   end

   // Stage 10: add the base origin when composing, then saturate.
   always_comb begin
      if (pay_ff[TRIG_STAGES+1].func == FUNC_POSE_TO_ABS) begin
         base_x_add = OX_W'(pay_ff[TRIG_STAGES+1].base_x);
         base_y_add = OX_W'(pay_ff[TRIG_STAGES+1].base_y);
      end else begin
         base_x_add = '0;
         base_y_add = '0;
      end
      ox_wide = OX_W'(rnd_x_ff) + base_x_add;
      oy_wide = OX_W'(rnd_y_ff) + base_y_add;

      // A value fits when all bits above its sign bit repeat the sign.
      ox_top = ox_wide[OX_W-1:POS_W-1];
      oy_top = oy_wide[OX_W-1:POS_W-1];
      oh_top = pay_ff[TRIG_STAGES+1].heading[HS_W-1:HEAD_W-1];
      ox_fit = (&ox_top) || !(|ox_top);
      oy_fit = (&oy_top) || !(|oy_top);
      oh_fit = (&oh_top) || !(|oh_top);

      out_x_in = ox_fit ? ox_wide[POS_W-1:0]
                        : {ox_wide[OX_W-1], {(POS_W-1){!ox_wide[OX_W-1]}}};
      out_y_in = oy_fit ? oy_wide[POS_W-1:0]
                        : {oy_wide[OX_W-1], {(POS_W-1){!oy_wide[OX_W-1]}}};
      out_heading_in = oh_fit ? pay_ff[TRIG_STAGES+1].heading[HEAD_W-1:0]
                              : {oh_top[1], {(HEAD_W-1){!oh_top[1]}}};
      saturated_in = !(ox_fit && oy_fit && oh_fit);
   end

   always_ff @(posedge clock) begin
      if (stage_en[NUM_STAGES-1]) begin
         out_x_ff       <= out_x_in;
         out_y_ff       <= out_y_in;
         out_heading_ff <= out_heading_in;
         saturated_ff   <= saturated_in;
      end
   end

   assign rsp_port.valid       = valid_ff[NUM_STAGES-1];
   assign rsp_port.out_x       = out_x_ff;
   assign rsp_port.out_y       = out_y_ff;
   assign rsp_port.out_heading = out_heading_ff;
   assign rsp_port.saturated   = saturated_ff;

endmodule

### hdl/pft_checker.sv
`include "assert_macros.svh"

module pft_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [pft_pkg::POS_W-1:0]   out_x,
   input logic signed [pft_pkg::POS_W-1:0]   out_y,
   input logic signed [pft_pkg::HEAD_W-1:0]  out_heading,
   input logic                               saturated
);
   import pft_pkg::*;

   localparam logic [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [HEAD_W-1:0] HEAD_MIN = {1'b1, {(HEAD_W-1){1'b0}}};
   localparam logic [HEAD_W-1:0] HEAD_MAX = {1'b0, {(HEAD_W-1){1'b1}}};

   logic                          sat_shown;
   logic                          pinned_at_limit;
   logic                          rsp_stalled;
   logic                          req_blocked;
   logic [2*POS_W+HEAD_W+1:0]     rsp_word;

   // Views of the ports that the properties below are written over.
   assign sat_shown       = rsp_valid && saturated;
   assign pinned_at_limit = (out_x == POS_MIN) || (out_x == POS_MAX) ||
                            (out_y == POS_MIN) || (out_y == POS_MAX) ||
                            (out_heading == HEAD_MIN) || (out_heading == HEAD_MAX);
   assign rsp_stalled     = rsp_valid && !rsp_ready;
   assign req_blocked     = req_valid && !req_ready;
   assign rsp_word        = {rsp_valid, out_x, out_y, out_heading, saturated};

   // A reset cycle empties the pipeline, so no result is shown after it.
   `PFT_ASSERT_AFTER_RESET(a_reset_empties, clock, reset, !rsp_valid, "result valid after reset")

   // A taken output frees every stage, so the input must be open too.
   `PFT_ASSERT_IMPLIES(a_ready_through, clock, reset, rsp_ready, req_ready, "input blocked while output drains")

   // A clipped result has at least one field pinned at a limit.
   `PFT_ASSERT_IMPLIES(a_sat_at_limit, clock, reset, sat_shown, pinned_at_limit, "no field at a limit")

   // A stalled result stays on the port unchanged.
   `PFT_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_stalled, $stable(rsp_word), "stalled result moved")

   // The input is only held off when every stage is full behind a stalled output.
   `PFT_ASSERT_IMPLIES(a_block_stall, clock, reset, req_blocked, rsp_stalled, "input blocked, no stall")

endmodule

bind planar_pose_frame_transform pft_checker u_pft_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_port.valid),
   .req_ready   (req_port.ready),
   .rsp_valid   (rsp_port.valid),
   .rsp_ready   (rsp_port.ready),
   .out_x       (rsp_port.out_x),
   .out_y       (rsp_port.out_y),
   .out_heading (rsp_port.out_heading),
   .saturated   (rsp_port.saturated)
);

### dv/tb_planar_pose_frame_transform.sv
module tb_planar_pose_frame_transform;
   timeunit 1ns;
   timeprecision 1ps;

   import pft_pkg::*;

   localparam int SINE_ENTRIES = TABLE_ENTRIES_DEFAULT;
   localparam int N_DIRECTED = 23;
   localparam int RANDOM_PER_PHASE = 643;
   localparam int unsigned CYCLE_LIMIT = 200000;

   localparam logic signed [POS_W-1:0]  POS_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [POS_W-1:0]  POS_MIN  = 32'sh8000_0000;
   localparam logic signed [HEAD_W-1:0] HEAD_MAX = 24'sh7F_FFFF;
   localparam logic signed [HEAD_W-1:0] HEAD_MIN = 24'sh80_0000;

   localparam longint POS_HI  = 64'sd2147483647;
   localparam longint POS_LO  = -64'sd2147483648;
   localparam longint HEAD_HI = 64'sd8388607;
   localparam longint HEAD_LO = -64'sd8388608;

   typedef struct packed {
      func_type                  func;
      logic signed [POS_W-1:0]   base_x;
      logic signed [POS_W-1:0]   base_y;
      logic signed [HEAD_W-1:0]  base_heading;
      logic signed [POS_W-1:0]   in_x;
      logic signed [POS_W-1:0]   in_y;
      logic signed [HEAD_W-1:0]  in_heading;
   } pose_request_type;

   typedef struct packed {
      logic signed [POS_W-1:0]   out_x;
      logic signed [POS_W-1:0]   out_y;
      logic signed [HEAD_W-1:0]  out_heading;
      logic                      saturated;
   } pose_result_type;

   typedef struct packed {
      pose_request_type req;
      logic             typed;
      pose_result_type  rsp;
   } directed_row_type;

   // Directed items. Rows with typed set carry a hand-worked result (heading
   // zero or a zero vector, so the rotation leaves the vector as it is); the rest are
   // left to the predictor.
   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // Everything zero straight after reset.
      '{'{FUNC_POSE_TO_ABS, 32'sd0, 32'sd0, 24'sd0, 32'sd0, 32'sd0, 24'sd0},
        1'b1, '{32'sd0, 32'sd0, 24'sd0, 1'b0}},
      // Position overflow upwards when composing.
      '{'{FUNC_POSE_TO_ABS, POS_MAX, 32'sd0, 24'sd0, 32'sd1000, 32'sd0, 24'sd0},
        1'b1, '{POS_MAX, 32'sd0, 24'sd0, 1'b1}},
      // Heading overflow on the sum; base heading reduces to a small angle.
      '{'{FUNC_POSE_TO_ABS, 32'sd0, 32'sd0, HEAD_MAX, 32'sd0, 32'sd0, 24'sd1},
        1'b1, '{32'sd0, 32'sd0, HEAD_MAX, 1'b1}},
      // Heading underflow on the difference.
      '{'{FUNC_POSE_TO_REL, 32'sd0, 32'sd0, 24'sd1, 32'sd0, 32'sd0, HEAD_MIN},
        1'b1, '{32'sd0, 32'sd0, HEAD_MIN, 1'b1}},
      // Vector modes pass the heading through untouched, never clipped.
      '{'{FUNC_VEC_INV, 32'sd0, 32'sd0, HEAD_MAX, 32'sd0, 32'sd0, HEAD_MIN},
        1'b1, '{32'sd0, 32'sd0, HEAD_MIN, 1'b0}},
      '{'{FUNC_VEC_FWD, 32'sd0, 32'sd0, HEAD_MIN, 32'sd0, 32'sd0, HEAD_MAX},
        1'b1, '{32'sd0, 32'sd0, HEAD_MAX, 1'b0}},
      // Difference of positions wider than 32 bits, both directions.
      '{'{FUNC_POSE_TO_REL, POS_MIN, 32'sd0, 24'sd0, POS_MAX, 32'sd0, 24'sd0},
        1'b1, '{POS_MAX, 32'sd0, 24'sd0, 1'b1}},
      '{'{FUNC_POSE_TO_REL, 32'sd5, POS_MAX, 24'sd0, 32'sd5, POS_MIN, 24'sd0},
        1'b1, '{32'sd0, POS_MIN, 24'sd0, 1'b1}},
      // Position overflow downwards when composing.
      '{'{FUNC_POSE_TO_ABS, POS_MIN, POS_MIN, 24'sd0, -32'sd1000, 32'sd0, 24'sd0},
        1'b1, '{POS_MIN, POS_MIN, 24'sd0, 1'b1}},
      // Quadrant boundaries and extremes of the vector fields.
      '{'{FUNC_VEC_FWD, 32'sd0, 32'sd0, 24'sd9000, POS_MAX, POS_MIN, 24'sd0},
        1'b0, '0},
      '{'{FUNC_VEC_INV, 32'sd0, 32'sd0, 24'sd9000, POS_MAX, POS_MIN, 24'sd0},
        1'b0, '0},
      '{'{FUNC_VEC_FWD, 32'sd0, 32'sd0, 24'sd18000, 32'sd1234567, -32'sd7654321,
          24'sd100}, 1'b0, '0},
      '{'{FUNC_VEC_FWD, 32'sd0, 32'sd0, 24'sd27000, 32'sd1234567, -32'sd7654321,
          24'sd100}, 1'b0, '0},
      '{'{FUNC_VEC_FWD, 32'sd0, 32'sd0, -24'sd9000, 32'sd1234567, -32'sd7654321,
          -24'sd100}, 1'b0, '0},
      '{'{FUNC_VEC_INV, 32'sd0, 32'sd0, 24'sd35999, POS_MIN, POS_MIN, 24'sd0},
        1'b0, '0},
      // Forty-five degrees with every position at its limit.
      '{'{FUNC_POSE_TO_ABS, POS_MAX, POS_MAX, 24'sd4500, POS_MAX, POS_MAX, 24'sd0},
        1'b0, '0},
      '{'{FUNC_POSE_TO_REL, POS_MAX, POS_MIN, 24'sd4500, POS_MIN, POS_MAX, 24'sd0},
        1'b0, '0},
      // Headings outside one turn, reduced for the lookup only.
      '{'{FUNC_POSE_TO_ABS, 32'sd100, -32'sd200, 24'sd36000, 32'sd5000, 32'sd7000,
          24'sd50}, 1'b0, '0},
      '{'{FUNC_POSE_TO_REL, 32'sd100, -32'sd200, -24'sd36001, 32'sd5000, 32'sd7000,
          24'sd50}, 1'b0, '0},
      '{'{FUNC_VEC_FWD, 32'sd0, 32'sd0, HEAD_MIN, 32'sd987654, 32'sd123456,
          24'sd77}, 1'b0, '0},
      // Ordinary angles.
      '{'{FUNC_POSE_TO_ABS, 32'sd160000, 32'sd80000, 24'sd3000, 32'sd16000,
          -32'sd4000, 24'sd1500}, 1'b0, '0},
      '{'{FUNC_VEC_INV, 32'sd0, 32'sd0, 24'sd12345, -32'sd33333, 32'sd44444,
          -24'sd250}, 1'b0, '0},
      '{'{FUNC_POSE_TO_REL, 32'sd0, 32'sd0, 24'sd1, 32'sd1, -32'sd1, 24'sd0},
        1'b0, '0}
   };

   logic clock;
   logic reset;

   pft_req_if req_chan ();
   pft_rsp_if rsp_chan ();

   planar_pose_frame_transform #(
      .TABLE_ENTRIES(SINE_ENTRIES)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_chan),
      .rsp_port (rsp_chan)
   );

   // Quarter-wave sine table in Q1.15, rebuilt here from the series.
   int sine_lut [SINE_ENTRIES];

   pose_result_type pending_poses [$];
   logic            req_typed;
   pose_result_type req_typed_rsp;

   int req_idle_pct;
   int rsp_stall_pct;
   int mismatch_count;
   int results_checked;
   int clipped_results;
   int func_seen [4];
   int unsigned cycle_count;

   pose_request_type acc_req;
   pose_result_type  want_pose;
   pose_result_type  got_pose;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      longint unsigned ang;
      longint unsigned ang_sq;
      longint unsigned term;
      longint unsigned acc;
      longint unsigned e;
      for (int i = 0; i < SINE_ENTRIES; i++) begin
         ang = longint'(i) * PI_Q30 / (2 * longint'(SINE_ENTRIES - 1));
         ang_sq = (ang * ang) >> 30;
         term = ang;
         acc = ang;
         for (longint unsigned k = 1; k <= 7; k++) begin
            term = ((term * ang_sq) >> 30) / ((2 * k) * (2 * k + 1));
            if (k[0]) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
         e = (acc * 32767 + (ONE_Q30 >> 1)) >> 30;
         if (e > 32767) begin
            e = 32767;
         end
         sine_lut[i] = int'(e);
      end
   end

   // Sine in Q1.15 of an angle already reduced to one turn.
   function automatic longint sine_at_cdeg(input int r);
      int quad;
      int rem;
      int idx;
      longint v;
      quad = r / CDEG_QUARTER;
      rem = r % CDEG_QUARTER;
      idx = (rem * (SINE_ENTRIES - 1) + CDEG_QUARTER / 2) / CDEG_QUARTER;
      if (idx > SINE_ENTRIES - 1) begin
         idx = SINE_ENTRIES - 1;
      end
      v = quad[0] ? sine_lut[SINE_ENTRIES - 1 - idx] : sine_lut[idx];
      return (quad >= 2) ? -v : v;
   endfunction

   // Round half up and drop the Q15 fraction.
   function automatic longint q15_round(input longint v);
      return (v + 64'sd16384) >>> 15;
   endfunction

   function automatic longint clamp_to(input longint v, input longint lo,
                                       input longint hi, inout logic hit);
      if (v < lo) begin
         hit = 1'b1;
         return lo;
      end
      if (v > hi) begin
         hit = 1'b1;
         return hi;
      end
      return v;
   endfunction

   // Expected result of one request.
   function automatic pose_result_type transform_pose(input pose_request_type r);
      longint bx, by, bh, ix, iy, ih;
      longint cs, sn, dx, dy, ox, oy, oh;
      int turn;
      logic hit;
      pose_result_type res;
      bx = $signed(r.base_x);
      by = $signed(r.base_y);
      bh = $signed(r.base_heading);
      ix = $signed(r.in_x);
      iy = $signed(r.in_y);
      ih = $signed(r.in_heading);
      turn = int'(bh % CDEG_TURN);
      if (turn < 0) begin
         turn = turn + CDEG_TURN;
      end
      sn = sine_at_cdeg(turn);
      cs = sine_at_cdeg((turn + CDEG_QUARTER) % CDEG_TURN);
      if (r.func == FUNC_POSE_TO_ABS || r.func == FUNC_VEC_FWD) begin
         ox = q15_round(cs * ix - sn * iy);
         oy = q15_round(sn * ix + cs * iy);
         if (r.func == FUNC_POSE_TO_ABS) begin
            ox = ox + bx;
            oy = oy + by;
            oh = ih + bh;
         end else begin
            oh = ih;
         end
      end else begin
         dx = ix;
         dy = iy;
         if (r.func == FUNC_POSE_TO_REL) begin
            dx = dx - bx;
            dy = dy - by;
            oh = ih - bh;
         end else begin
            oh = ih;
         end
         ox = q15_round(cs * dx + sn * dy);
         oy = q15_round(cs * dy - sn * dx);
      end
      hit = 1'b0;
      ox = clamp_to(ox, POS_LO, POS_HI, hit);
      oy = clamp_to(oy, POS_LO, POS_HI, hit);
      oh = clamp_to(oh, HEAD_LO, HEAD_HI, hit);
      res.out_x = ox[POS_W-1:0];
      res.out_y = oy[POS_W-1:0];
      res.out_heading = oh[HEAD_W-1:0];
      res.saturated = hit;
      return res;
   endfunction

   // Positions: limits, small, medium and full-range values.
   function automatic logic signed [POS_W-1:0] random_coord();
      logic signed [POS_W-1:0] v;
      case ($urandom_range(9))
         0: v = POS_MAX;
         1: v = POS_MIN;
         2, 3, 4: v = $signed($urandom_range(2000)) - 32'sd1000;
         5: v = $signed($urandom_range(2097151)) - 32'sd1048576;
         default: v = $urandom();
      endcase
      return v;
   endfunction

   // Headings: limits, near quadrant boundaries, within 40000 of zero, full range.
   function automatic logic signed [HEAD_W-1:0] random_heading();
      int t;
      case ($urandom_range(9))
         0: t = int'(HEAD_MAX);
         1: t = int'(HEAD_MIN);
         2: t = CDEG_QUARTER * (int'($urandom_range(16)) - 8)
                + int'($urandom_range(6)) - 3;
         3, 4, 5: t = int'($urandom_range(80000)) - 40000;
         default: t = int'($urandom());
      endcase
      return t[HEAD_W-1:0];
   endfunction

   // Offer one item, with random idle cycles in front, and hold it until taken.
   task automatic drive_request(input pose_request_type r, input logic typed,
                                input pose_result_type rsp);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.func         <= r.func;
      req_chan.base_x       <= r.base_x;
      req_chan.base_y       <= r.base_y;
      req_chan.base_heading <= r.base_heading;
      req_chan.in_x         <= r.in_x;
      req_chan.in_y         <= r.in_y;
      req_chan.in_heading   <= r.in_heading;
      req_typed             <= typed;
      req_typed_rsp         <= rsp;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
   endtask

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Queue an expected result for every accepted item and check every accepted result in order.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            acc_req.func         = func_type'(req_chan.func);
            acc_req.base_x       = req_chan.base_x;
            acc_req.base_y       = req_chan.base_y;
            acc_req.base_heading = req_chan.base_heading;
            acc_req.in_x         = req_chan.in_x;
            acc_req.in_y         = req_chan.in_y;
            acc_req.in_heading   = req_chan.in_heading;
            func_seen[acc_req.func]++;
            if (req_typed) begin
               pending_poses.push_back(req_typed_rsp);
            end else begin
               pending_poses.push_back(transform_pose(acc_req));
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_pose.out_x       = rsp_chan.out_x;
            got_pose.out_y       = rsp_chan.out_y;
            got_pose.out_heading = rsp_chan.out_heading;
            got_pose.saturated   = rsp_chan.saturated;
            if (pending_poses.size() == 0) begin
               $error("result item with nothing expected: x %0d y %0d heading %0d",
                      got_pose.out_x, got_pose.out_y, got_pose.out_heading);
               mismatch_count++;
            end else begin
               want_pose = pending_poses.pop_front();
               results_checked++;
               if (got_pose.saturated) begin
                  clipped_results++;
               end
               if (got_pose.out_x !== want_pose.out_x) begin
                  $error("out_x: expected %0d, got %0d", want_pose.out_x, got_pose.out_x);
                  mismatch_count++;
               end
               if (got_pose.out_y !== want_pose.out_y) begin
                  $error("out_y: expected %0d, got %0d", want_pose.out_y, got_pose.out_y);
                  mismatch_count++;
               end
               if (got_pose.out_heading !== want_pose.out_heading) begin
                  $error("out_heading: expected %0d, got %0d",
                         want_pose.out_heading, got_pose.out_heading);
                  mismatch_count++;
               end
               if (got_pose.saturated !== want_pose.saturated) begin
                  $error("saturated: expected %0d, got %0d",
                         want_pose.saturated, got_pose.saturated);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Stimulus: reset, directed table, then three random phases with different idle and stall rates.
   initial begin
      pose_request_type r;
      req_idle_pct = 15;
      rsp_stall_pct = 59;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.func         <= FUNC_POSE_TO_ABS;
      req_chan.base_x       <= '0;
      req_chan.base_y       <= '0;
      req_chan.base_heading <= '0;
      req_chan.in_x         <= '0;
      req_chan.in_y         <= '0;
      req_chan.in_heading   <= '0;
      req_typed             <= 1'b0;
      req_typed_rsp         <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         drive_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed,
                       DIRECTED_ROWS[i].rsp);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 15;
               rsp_stall_pct = 59;
            end
            1: begin
               req_idle_pct = 59;
               rsp_stall_pct = 15;
            end
            default: begin
               req_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         repeat (RANDOM_PER_PHASE) begin
            r.func         = func_type'($urandom_range(3));
            r.base_x       = random_coord();
            r.base_y       = random_coord();
            r.base_heading = random_heading();
            r.in_x         = random_coord();
            r.in_y         = random_coord();
            r.in_heading   = random_heading();
            drive_request(r, 1'b0, '0);
         end
      end
      req_chan.valid <= 1'b0;

      // Drain, then leave room for any stray result behind the last one.
      @(posedge clock);
      while (pending_poses.size() != 0) begin
         @(posedge clock);
      end
      repeat (30) @(posedge clock);

      $display("Transforms checked: %0d, of which to absolute %0d, to relative %0d,",
               results_checked, func_seen[FUNC_POSE_TO_ABS], func_seen[FUNC_POSE_TO_REL]);
      $display("vector forward %0d and vector inverse %0d.",
               func_seen[FUNC_VEC_FWD], func_seen[FUNC_VEC_INV]);
      $display("Clipped results: %0d; field mismatches: %0d.", clipped_results,
               mismatch_count);
      if (mismatch_count == 0 && pending_poses.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
